>>> hw/rtl/ile_pkg.sv
// Package for the indexed list engine: sizes, request and response words,
// slot memory records, state codes. Used by every file of the block.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY  = 256;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 9;

    typedef logic [ADDR_W-1:0] t_slot_idx;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [2:0] {
        K_READ   = 3'd0,
        K_WRITE  = 3'd1,
        K_APPEND = 3'd2,
        K_INSERT = 3'd3,
        K_POP    = 3'd4,
        K_REMOVE = 3'd5,
        K_CLEAR  = 3'd6,
        K_NONE   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind                        kind;
        logic [POS_W-1:0]             position;
        logic signed [WORD_BITS-1:0]  word;
    } t_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]  read_word;
        t_status                      status;
        logic [POS_W-1:0]             count_after;
        logic                         list_empty;
    } t_rsp;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        t_slot_idx            fwd;
        t_slot_idx            bwd;
    } t_slot;

    typedef struct packed {
        logic word;
        logic fwd;
        logic bwd;
    } t_slot_we;

    typedef struct packed {
        logic      valid;
        t_slot_idx addr;
        t_slot_we  we;
        t_slot     data;
    } t_wplan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOC,
        S_WALK,
        S_OP,
        S_WRITE,
        S_FINISH
    } t_state;

endpackage

>>> hw/rtl/ile_slot_mem.sv
// Single-port slot memory holding each slot's word and both links.
// Per-field write enables; registered read data. Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_slot_mem (
    input  logic              i_clk,
    input  ile_pkg::t_slot_idx i_addr,
    input  ile_pkg::t_slot_we i_we,
    input  ile_pkg::t_slot    i_wdata,
    output ile_pkg::t_slot    o_rdata
);

    logic [ile_pkg::WORD_BITS-1:0] mem_word [ile_pkg::CAPACITY];
    ile_pkg::t_slot_idx            mem_fwd  [ile_pkg::CAPACITY];
    ile_pkg::t_slot_idx            mem_bwd  [ile_pkg::CAPACITY];
    ile_pkg::t_slot                r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we.word) begin
            mem_word[i_addr] <= i_wdata.word;
        end
        if (i_we.fwd) begin
            mem_fwd[i_addr] <= i_wdata.fwd;
        end
        if (i_we.bwd) begin
            mem_bwd[i_addr] <= i_wdata.bwd;
        end
        r_rdata.word <= mem_word[i_addr];
        r_rdata.fwd  <= mem_fwd[i_addr];
        r_rdata.bwd  <= mem_bwd[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ile_free_mem.sv
// Free-slot stack memory: one write port and one read port, registered read.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_free_mem (
    input  logic               i_clk,
    input  logic               i_we,
    input  ile_pkg::t_slot_idx i_waddr,
    input  ile_pkg::t_slot_idx i_wdata,
    input  ile_pkg::t_slot_idx i_raddr,
    output ile_pkg::t_slot_idx o_rdata
);

    ile_pkg::t_slot_idx mem [ile_pkg::CAPACITY];
    ile_pkg::t_slot_idx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/indexed_list_engine.sv
// Top level of the indexed list engine: request sequencer, list registers,
// output register. Uses ile_pkg, ile_slot_mem and ile_free_mem.
//
//   channel  valid        stall        payload
//   request  i_req_valid  o_req_stall  i_req (t_req)
//   response o_rsp_valid  i_rsp_stall  o_rsp (t_rsp)
//
// One request at a time. A request moves through the states idle, prep,
// locate, walk (one step per link followed), op, write and finish. An
// append skips locate and walk; a failed check, a clear or K_NONE goes
// from prep to finish. The walk starts at the nearer end, so at most
// CAPACITY/2 - 1 steps. Reset is synchronous and needs no clearing pass.
// A new request is taken while the previous response still waits under stall.
`timescale 1ns / 1ps

module indexed_list_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  ile_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output ile_pkg::t_rsp o_rsp
);

    localparam int ADDR_W = ile_pkg::ADDR_W;
    localparam int CNT_W  = ile_pkg::CNT_W;

    ile_pkg::t_state    r_state, n_state;
    ile_pkg::t_req      r_req, n_req;
    ile_pkg::t_count    r_count, n_count;
    ile_pkg::t_slot_idx r_first, n_first;
    ile_pkg::t_slot_idx r_last, n_last;
    ile_pkg::t_count    r_min_top, n_min_top;
    ile_pkg::t_slot_idx r_new, n_new;
    ile_pkg::t_slot_idx r_cur, n_cur;
    ile_pkg::t_count    r_steps, n_steps;
    logic               r_fwd_dir, n_fwd_dir;
    ile_pkg::t_wplan    r_plan [3];
    ile_pkg::t_wplan    n_plan [3];
    logic [1:0]         r_wi, n_wi;
    logic [ile_pkg::WORD_BITS-1:0] r_rd, n_rd;
    ile_pkg::t_status   r_status, n_status;
    logic               r_out_valid, n_out_valid;
    ile_pkg::t_rsp      r_out, n_out;

    ile_pkg::t_slot_idx slot_addr;
    ile_pkg::t_slot_we  slot_we;
    ile_pkg::t_slot     slot_wdata;
    ile_pkg::t_slot     slot_rdata;
    logic               free_we;
    ile_pkg::t_slot_idx free_rdata;

    ile_pkg::t_count    free_top;
    ile_pkg::t_slot_idx push_idx;
    ile_pkg::t_slot_idx pop_idx;
    ile_pkg::t_count    pos;
    ile_pkg::t_slot_idx walk_next;

    assign free_top  = CNT_W'(ile_pkg::CAPACITY) - r_count;
    assign push_idx  = free_top[ADDR_W-1:0];
    assign pop_idx   = push_idx - ADDR_W'(1);
    assign pos       = r_req.position;
    assign walk_next = r_fwd_dir ? slot_rdata.fwd : slot_rdata.bwd;

    ile_slot_mem u_slot_mem (
        .i_clk   (i_clk),
        .i_addr  (slot_addr),
        .i_we    (slot_we),
        .i_wdata (slot_wdata),
        .o_rdata (slot_rdata)
    );

    ile_free_mem u_free_mem (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (push_idx),
        .i_wdata (r_cur),
        .i_raddr (pop_idx),
        .o_rdata (free_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ile_pkg::S_IDLE;
            r_count     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_min_top   <= CNT_W'(ile_pkg::CAPACITY);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_last      <= n_last;
            r_min_top   <= n_min_top;
            r_out_valid <= n_out_valid;
        end
        r_req     <= n_req;
        r_new     <= n_new;
        r_cur     <= n_cur;
        r_steps   <= n_steps;
        r_fwd_dir <= n_fwd_dir;
        r_plan    <= n_plan;
        r_wi      <= n_wi;
        r_rd      <= n_rd;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_first     = r_first;
        n_last      = r_last;
        n_min_top   = r_min_top;
        n_new       = r_new;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_fwd_dir   = r_fwd_dir;
        n_plan      = r_plan;
        n_wi        = r_wi;
        n_rd        = r_rd;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        slot_addr   = r_cur;
        slot_we     = '0;
        slot_wdata  = '0;
        free_we     = 1'b0;

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ile_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_rd     = '0;
                    n_status = ile_pkg::ST_OK;
                    n_state  = ile_pkg::S_PREP;
                end
            end
            ile_pkg::S_PREP: begin
                if (CNT_W'(pop_idx) < r_min_top) begin
                    n_new = ADDR_W'(ile_pkg::CAPACITY - 1) - pop_idx;
                end else begin
                    n_new = free_rdata;
                end
                if (pos < (r_count >> 1)) begin
                    n_cur     = r_first;
                    n_steps   = pos;
                    n_fwd_dir = 1'b1;
                end else begin
                    n_cur     = r_last;
                    n_steps   = r_count - CNT_W'(1) - pos;
                    n_fwd_dir = 1'b0;
                end
                n_state = ile_pkg::S_LOC;
                unique case (r_req.kind)
                    ile_pkg::K_READ, ile_pkg::K_WRITE, ile_pkg::K_REMOVE: begin
                        if (pos >= r_count) begin
                            n_status = ile_pkg::ST_RANGE;
                            n_state  = ile_pkg::S_FINISH;
                        end
                    end
                    ile_pkg::K_APPEND: begin
                        if (r_count >= CNT_W'(ile_pkg::CAPACITY)) begin
                            n_status = ile_pkg::ST_FULL;
                            n_state  = ile_pkg::S_FINISH;
                        end else begin
                            n_state = ile_pkg::S_OP;
                        end
                    end
                    ile_pkg::K_INSERT: begin
                        if (pos > r_count) begin
                            n_status = ile_pkg::ST_RANGE;
                            n_state  = ile_pkg::S_FINISH;
                        end else if (r_count >= CNT_W'(ile_pkg::CAPACITY)) begin
                            n_status = ile_pkg::ST_FULL;
                            n_state  = ile_pkg::S_FINISH;
                        end else if (pos == r_count) begin
                            n_req.kind = ile_pkg::K_APPEND;
                            n_state    = ile_pkg::S_OP;
                        end
                    end
                    ile_pkg::K_POP: begin
                        n_cur   = r_last;
                        n_steps = '0;
                        if (r_count == '0) begin
                            n_status = ile_pkg::ST_EMPTY;
                            n_state  = ile_pkg::S_FINISH;
                        end
                    end
                    ile_pkg::K_CLEAR: begin
                        n_count   = '0;
                        n_first   = '0;
                        n_last    = '0;
                        n_min_top = CNT_W'(ile_pkg::CAPACITY);
                        n_state   = ile_pkg::S_FINISH;
                    end
                    default: begin
                        n_state = ile_pkg::S_FINISH;
                    end
                endcase
            end
            ile_pkg::S_LOC: begin
                slot_addr = r_cur;
                if (r_steps == '0) begin
                    n_state = ile_pkg::S_OP;
                end else begin
                    n_state = ile_pkg::S_WALK;
                end
            end
            ile_pkg::S_WALK: begin
                slot_addr = walk_next;
                n_cur     = walk_next;
                n_steps   = r_steps - CNT_W'(1);
                if (r_steps == CNT_W'(1)) begin
                    n_state = ile_pkg::S_OP;
                end
            end
            ile_pkg::S_OP: begin
                for (int i = 0; i < 3; i++) begin
                    n_plan[i] = '0;
                end
                n_wi    = '0;
                n_state = ile_pkg::S_WRITE;
                unique case (r_req.kind)
                    ile_pkg::K_READ: begin
                        n_rd = slot_rdata.word;
                    end
                    ile_pkg::K_WRITE: begin
                        n_plan[0].valid     = 1'b1;
                        n_plan[0].addr      = r_cur;
                        n_plan[0].we.word   = 1'b1;
                        n_plan[0].data.word = r_req.word;
                    end
                    ile_pkg::K_APPEND: begin
                        n_plan[0].valid     = 1'b1;
                        n_plan[0].addr      = r_new;
                        n_plan[0].we.word   = 1'b1;
                        n_plan[0].we.bwd    = 1'b1;
                        n_plan[0].data.word = r_req.word;
                        n_plan[0].data.bwd  = r_last;
                        if (r_count == '0) begin
                            n_first = r_new;
                        end else begin
                            n_plan[1].valid    = 1'b1;
                            n_plan[1].addr     = r_last;
                            n_plan[1].we.fwd   = 1'b1;
                            n_plan[1].data.fwd = r_new;
                        end
                        n_last  = r_new;
                        n_count = r_count + CNT_W'(1);
                        if (CNT_W'(pop_idx) < r_min_top) begin
                            n_min_top = CNT_W'(pop_idx);
                        end
                    end
                    ile_pkg::K_INSERT: begin
                        n_plan[0].valid     = 1'b1;
                        n_plan[0].addr      = r_new;
                        n_plan[0].we        = '1;
                        n_plan[0].data.word = r_req.word;
                        n_plan[0].data.fwd  = r_cur;
                        n_plan[0].data.bwd  = slot_rdata.bwd;
                        if (pos == '0) begin
                            n_first = r_new;
                        end else begin
                            n_plan[1].valid    = 1'b1;
                            n_plan[1].addr     = slot_rdata.bwd;
                            n_plan[1].we.fwd   = 1'b1;
                            n_plan[1].data.fwd = r_new;
                        end
                        n_plan[2].valid    = 1'b1;
                        n_plan[2].addr     = r_cur;
                        n_plan[2].we.bwd   = 1'b1;
                        n_plan[2].data.bwd = r_new;
                        n_count = r_count + CNT_W'(1);
                        if (CNT_W'(pop_idx) < r_min_top) begin
                            n_min_top = CNT_W'(pop_idx);
                        end
                    end
                    ile_pkg::K_POP: begin
                        n_rd    = slot_rdata.word;
                        n_last  = slot_rdata.bwd;
                        free_we = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                    ile_pkg::K_REMOVE: begin
                        n_rd = slot_rdata.word;
                        if (pos == '0) begin
                            n_first = slot_rdata.fwd;
                        end else begin
                            n_plan[0].valid    = 1'b1;
                            n_plan[0].addr     = slot_rdata.bwd;
                            n_plan[0].we.fwd   = 1'b1;
                            n_plan[0].data.fwd = slot_rdata.fwd;
                        end
                        if (pos == r_count - CNT_W'(1)) begin
                            n_last = slot_rdata.bwd;
                        end else begin
                            n_plan[1].valid    = 1'b1;
                            n_plan[1].addr     = slot_rdata.fwd;
                            n_plan[1].we.bwd   = 1'b1;
                            n_plan[1].data.bwd = slot_rdata.bwd;
                        end
                        free_we = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            ile_pkg::S_WRITE: begin
                slot_addr  = r_plan[r_wi].addr;
                slot_wdata = r_plan[r_wi].data;
                slot_we    = r_plan[r_wi].valid ? r_plan[r_wi].we : '0;
                n_wi       = r_wi + 2'd1;
                if (r_wi == 2'd2) begin
                    n_state = ile_pkg::S_FINISH;
                end
            end
            ile_pkg::S_FINISH: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.read_word   = r_rd;
                    n_out.status      = r_status;
                    n_out.count_after = r_count;
                    n_out.list_empty  = (r_count == '0);
                    n_state           = ile_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ile_pkg::S_IDLE;
            end
        endcase
    end

    assign o_req_stall = (r_state != ile_pkg::S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

>>> hw/rtl/ile_checker.sv
// Port-level checks for the indexed list engine, bound to the top level.
// Depends on ile_pkg and indexed_list_engine.
`timescale 1ns / 1ps

module ile_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input ile_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_stall,
    input ile_pkg::t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("Stalled response word changed.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.list_empty == (o_rsp.count_after == '0))
        else $error("Empty flag disagrees with the count.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ile_pkg::ST_OK |-> o_rsp.read_word == '0)
        else $error("Failed request returned a nonzero word.");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.count_after <= ile_pkg::POS_W'(ile_pkg::CAPACITY))
        else $error("Count exceeds capacity.");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("Engine took no time for an accepted request.");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);

>>> test/indexed_list_engine_tb.sv
// Testbench for the indexed list engine: random and directed list requests,
// with a list model in a scoreboard class that checks every response word.
// Depends on ile_pkg and the indexed_list_engine top level.
`timescale 1ns / 1ps

module indexed_list_engine_tb;

    class list_scoreboard;
        int           list_words[$];
        ile_pkg::t_rsp pending_rsp[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(ile_pkg::t_req rq);
            ile_pkg::t_rsp rs;
            int            cnt;
            int            pos;
            rs = '0;
            rs.status = ile_pkg::ST_OK;
            cnt = list_words.size();
            pos = int'(rq.position);
            case (rq.kind)
                ile_pkg::K_READ, ile_pkg::K_WRITE: begin
                    if (pos >= cnt) begin
                        rs.status = ile_pkg::ST_RANGE;
                    end else if (rq.kind == ile_pkg::K_READ) begin
                        rs.read_word = list_words[pos];
                    end else begin
                        list_words[pos] = rq.word;
                    end
                end
                ile_pkg::K_APPEND: begin
                    if (cnt >= ile_pkg::CAPACITY) begin
                        rs.status = ile_pkg::ST_FULL;
                    end else begin
                        list_words.push_back(rq.word);
                    end
                end
                ile_pkg::K_INSERT: begin
                    if (pos > cnt) begin
                        rs.status = ile_pkg::ST_RANGE;
                    end else if (cnt >= ile_pkg::CAPACITY) begin
                        rs.status = ile_pkg::ST_FULL;
                    end else begin
                        list_words.insert(pos, rq.word);
                    end
                end
                ile_pkg::K_POP: begin
                    if (cnt == 0) begin
                        rs.status = ile_pkg::ST_EMPTY;
                    end else begin
                        rs.read_word = list_words.pop_back();
                    end
                end
                ile_pkg::K_REMOVE: begin
                    if (pos >= cnt) begin
                        rs.status = ile_pkg::ST_RANGE;
                    end else begin
                        rs.read_word = list_words[pos];
                        list_words.delete(pos);
                    end
                end
                ile_pkg::K_CLEAR: begin
                    list_words.delete();
                end
                default: begin
                end
            endcase
            rs.count_after = ile_pkg::POS_W'(list_words.size());
            rs.list_empty = (list_words.size() == 0);
            pending_rsp.push_back(rs);
        endfunction

        function void check_response(ile_pkg::t_rsp got);
            ile_pkg::t_rsp exp;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $realtime, got);
                errors++;
                return;
            end
            exp = pending_rsp.pop_front();
            if (got.read_word !== exp.read_word) begin
                $display("%0t: read_word expected %0d actual %0d", $realtime,
                         exp.read_word, got.read_word);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime,
                         exp.status, got.status);
                errors++;
            end
            if (got.count_after !== exp.count_after) begin
                $display("%0t: count_after expected %0d actual %0d", $realtime,
                         exp.count_after, got.count_after);
                errors++;
            end
            if (got.list_empty !== exp.list_empty) begin
                $display("%0t: list_empty expected %0d actual %0d", $realtime,
                         exp.list_empty, got.list_empty);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_req_valid;
    logic          o_req_stall;
    ile_pkg::t_req i_req;
    logic          o_rsp_valid;
    logic          i_rsp_stall;
    ile_pkg::t_rsp o_rsp;

    list_scoreboard board;
    int             idle_cycles;
    bit             timed_out;
    int             stall_mode;

    indexed_list_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_rsp_stall = 1'b0;
        idle_cycles = 0;
        timed_out = 1'b0;
        stall_mode = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) begin
                board.check_response(o_rsp);
            end
            if ((o_rsp_valid && !i_rsp_stall) || (i_req_valid && !o_req_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles > 20000) begin
                timed_out = 1'b1;
            end
            if ($urandom_range(0, 199) == 0) begin
                stall_mode <= $urandom_range(0, 3);
            end
            case (stall_mode)
                0: i_rsp_stall <= 1'b0;
                1: i_rsp_stall <= ($urandom_range(0, 3) == 0);
                2: i_rsp_stall <= ($urandom_range(0, 1) == 0);
                default: i_rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial begin
        wait (timed_out);
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(input ile_pkg::t_kind k, input int pos,
                                input logic [31:0] w);
        ile_pkg::t_req rq;
        rq.kind = k;
        rq.position = pos[8:0];
        rq.word = w;
        i_req_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (o_req_stall) begin
            @(posedge i_clk);
        end
        board.note_request(rq);
    endtask

    task automatic pause_sender(input int n);
        i_req_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_request();
        int            r;
        int            cnt;
        int            pos;
        ile_pkg::t_kind k;
        cnt = board.list_words.size();
        r = $urandom_range(0, 99);
        if (r < 22) k = ile_pkg::K_APPEND;
        else if (r < 40) k = ile_pkg::K_INSERT;
        else if (r < 58) k = ile_pkg::K_READ;
        else if (r < 70) k = ile_pkg::K_WRITE;
        else if (r < 80) k = ile_pkg::K_POP;
        else if (r < 94) k = ile_pkg::K_REMOVE;
        else if (r < 96) k = ile_pkg::K_CLEAR;
        else if (r < 98) k = ile_pkg::K_NONE;
        else k = ile_pkg::t_kind'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, 511);
        end else if ($urandom_range(0, 3) == 0 && cnt > 0) begin
            pos = ($urandom_range(0, 1) == 0) ? 0 : cnt - 1;
        end else begin
            pos = $urandom_range(0, cnt);
        end
        send_request(k, pos, $urandom());
    endtask

    initial begin
        int i;
        int burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ile_pkg::K_POP, 0, 32'h0);
        send_request(ile_pkg::K_READ, 0, 32'h0);
        send_request(ile_pkg::K_REMOVE, 0, 32'h0);
        send_request(ile_pkg::K_INSERT, 1, 32'h1);
        send_request(ile_pkg::K_INSERT, 0, 32'h7fffffff);
        send_request(ile_pkg::K_APPEND, 0, 32'h80000000);
        send_request(ile_pkg::K_APPEND, 0, 32'hffffffff);
        send_request(ile_pkg::K_INSERT, 3, 32'h0);
        send_request(ile_pkg::K_INSERT, 1, 32'h55555555);
        send_request(ile_pkg::K_READ, 4, 32'h0);
        send_request(ile_pkg::K_READ, 5, 32'h0);
        send_request(ile_pkg::K_WRITE, 2, 32'haaaaaaaa);
        send_request(ile_pkg::K_READ, 2, 32'h0);
        send_request(ile_pkg::K_READ, 511, 32'h0);
        send_request(ile_pkg::K_NONE, 0, 32'h12345678);
        send_request(ile_pkg::K_REMOVE, 0, 32'h0);
        send_request(ile_pkg::K_REMOVE, 3, 32'h0);
        send_request(ile_pkg::K_POP, 0, 32'h0);
        send_request(ile_pkg::K_CLEAR, 0, 32'h0);
        send_request(ile_pkg::K_POP, 0, 32'h0);

        // Fill the store to capacity to reach the full status, then clear it.
        for (i = 0; i < ile_pkg::CAPACITY; i++) begin
            send_request(ile_pkg::K_APPEND, 0, $urandom());
        end
        send_request(ile_pkg::K_APPEND, 0, 32'h1);
        send_request(ile_pkg::K_INSERT, 256, 32'h2);
        send_request(ile_pkg::K_INSERT, 10, 32'h3);
        send_request(ile_pkg::K_READ, 255, 32'h0);
        send_request(ile_pkg::K_READ, 127, 32'h0);
        send_request(ile_pkg::K_REMOVE, 128, 32'h0);
        send_request(ile_pkg::K_INSERT, 128, 32'h4);
        send_request(ile_pkg::K_CLEAR, 0, 32'h0);

        i = 0;
        while (i < 1300) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && i < 1300) begin
                random_request();
                burst--;
                i++;
                if (i == 650) begin
                    burst = 0;
                end
            end
            if (i == 650) begin
                i_req_valid <= 1'b0;
                while (board.pending_rsp.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 2) != 0) begin
                pause_sender($urandom_range(1, 40));
            end
        end
        i_req_valid <= 1'b0;

        while (board.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.pending_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> indexed_list_engine.f
hw/rtl/ile_pkg.sv
hw/rtl/ile_slot_mem.sv
hw/rtl/ile_free_mem.sv
hw/rtl/indexed_list_engine.sv
hw/rtl/ile_checker.sv
test/indexed_list_engine_tb.sv
